[rtl/core/tts_pkg.sv]
// package for the timer table scheduler
// shared constants, request and status codes, controller/datapath structs
package tts_pkg;

    localparam int TIMER_SLOTS_DEFAULT = 16;
    localparam int KEY_W = 32;
    localparam int TAG_W = 16;

    typedef enum logic [1:0] {
        REQ_REG_ONESHOT  = 2'd0,
        REQ_REG_PERIODIC = 2'd1,
        REQ_UNREGISTER   = 2'd2,
        REQ_PROCESS      = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_DUP_KEY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SCAN_MATCH = 2'd0,
        SCAN_MIN   = 2'd1
    } scan_mode_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       scan_step;
        scan_mode_t scan_mode;
        logic       do_register;
        logic       do_free_match;
        logic       do_fire;
        logic       do_rearm;
        logic       set_sleep;
        logic       set_dup;
        logic       set_notfound;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic match_found;
        logic free_found;
        logic min_found;
        logic min_due;
        logic min_periodic;
    } dp_stat_t;

endpackage

[rtl/core/timer_table_scheduler.sv]
// Timer table scheduler, top level: one request in, one result out. Each request
// scans the slot table one slot per cycle. Register and unregister do one match scan;
// process does a minimum scan and, when a timer fires, a second minimum scan, with a
// match scan before it when a periodic timer is re-armed (its new key is checked
// against all slots); the result then waits in its register until taken, and the
// next request can be accepted in the cycle after it is taken.
// Depends on tts_pkg, tts_ctrl, tts_datapath.
module timer_table_scheduler #(
    parameter int TIMER_SLOTS = tts_pkg::TIMER_SLOTS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [31:0]        s_now_ms,
    input  logic [31:0]        s_duration_ms,
    input  logic [31:0]        s_timer_id,
    input  logic [15:0]        s_user_tag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [31:0]        m_new_id,
    output logic               m_fired,
    output logic [31:0]        m_fired_key,
    output logic [15:0]        m_fired_tag,
    output logic signed [31:0] m_sleep_ms,
    output logic               m_table_empty
);
    import tts_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tts_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    tts_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_req_type    (s_req_type),
        .s_now_ms      (s_now_ms),
        .s_duration_ms (s_duration_ms),
        .s_timer_id    (s_timer_id),
        .s_user_tag    (s_user_tag),
        .r_status      (m_status),
        .r_new_id      (m_new_id),
        .r_fired       (m_fired),
        .r_fired_key   (m_fired_key),
        .r_fired_tag   (m_fired_tag),
        .r_sleep_ms    (m_sleep_ms),
        .r_table_empty (m_table_empty)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_sleep_ms))
        else $error("result changed while stalled");

    a_empty_sleep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_table_empty |-> m_sleep_ms == -32'sd1)
        else $error("empty table without sleep of minus one");

endmodule

[rtl/core/tts_datapath.sv]
// datapath: slot table, request registers, one-slot-per-cycle scan unit
// depends on tts_pkg
module tts_datapath #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tts_pkg::dp_cmd_t         cmd,
    output tts_pkg::dp_stat_t        stat,
    input  logic [1:0]               s_req_type,
    input  logic [31:0]              s_now_ms,
    input  logic [31:0]              s_duration_ms,
    input  logic [31:0]              s_timer_id,
    input  logic [15:0]              s_user_tag,
    output logic [1:0]               r_status,
    output logic [31:0]              r_new_id,
    output logic                     r_fired,
    output logic [31:0]              r_fired_key,
    output logic [15:0]              r_fired_tag,
    output logic signed [31:0]       r_sleep_ms,
    output logic                     r_table_empty
);
    import tts_pkg::*;

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    logic [TIMER_SLOTS-1:0] valid_reg;
    logic [31:0] expiry_mem [TIMER_SLOTS];
    logic [31:0] period_mem [TIMER_SLOTS];
    logic        periodic_mem [TIMER_SLOTS];
    logic [15:0] tag_mem [TIMER_SLOTS];

    logic [1:0]  req_reg;
    logic [31:0] now_reg, dur_reg, key_reg;
    logic [15:0] tag_reg;
    logic [IDX_W-1:0] idx_reg;
    logic match_reg, free_reg, min_reg;
    logic [IDX_W-1:0] match_idx_reg, free_idx_reg, min_idx_reg;
    logic [31:0] min_key_reg;
    logic [1:0]  status_reg;
    logic [31:0] new_id_reg, fkey_reg, sleep_reg;
    logic [15:0] ftag_reg;
    logic fired_reg, empty_reg;

    logic [31:0] cur_key;
    logic        cur_valid;

    assign cur_key   = expiry_mem[idx_reg];
    assign cur_valid = valid_reg[idx_reg];

    assign stat.scan_last    = (idx_reg == IDX_W'(TIMER_SLOTS - 1));
    assign stat.match_found  = match_reg;
    assign stat.free_found   = free_reg;
    assign stat.min_found    = min_reg;
    assign stat.min_due      = (min_key_reg <= now_reg);
    assign stat.min_periodic = periodic_mem[min_idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (cmd.do_register) begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.do_free_match) begin
                valid_reg[match_idx_reg] <= 1'b0;
            end
            if (cmd.do_fire && !cmd.do_rearm) begin
                valid_reg[min_idx_reg] <= 1'b0;
            end
            if (cmd.do_rearm) begin
                valid_reg[min_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_register) begin
            expiry_mem[free_idx_reg]   <= key_reg;
            period_mem[free_idx_reg]   <= dur_reg;
            periodic_mem[free_idx_reg] <= (req_reg == REQ_REG_PERIODIC);
            tag_mem[free_idx_reg]      <= tag_reg;
        end
        if (cmd.do_rearm) begin
            expiry_mem[min_idx_reg] <= key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= s_req_type;
            now_reg    <= s_now_ms;
            dur_reg    <= s_duration_ms;
            tag_reg    <= s_user_tag;
            key_reg    <= (s_req_type == REQ_UNREGISTER) ? s_timer_id
                                                         : s_now_ms + s_duration_ms;
            status_reg <= ST_OK;
            new_id_reg <= '0;
            fired_reg  <= 1'b0;
            fkey_reg   <= '0;
            ftag_reg   <= '0;
            sleep_reg  <= '0;
            empty_reg  <= 1'b0;
        end
        if (cmd.scan_start) begin
            idx_reg   <= '0;
            match_reg <= 1'b0;
            free_reg  <= 1'b0;
            min_reg   <= 1'b0;
        end
        if (cmd.scan_step) begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (cmd.scan_mode == SCAN_MATCH) begin
                if (cur_valid && cur_key == key_reg && !match_reg) begin
                    match_reg     <= 1'b1;
                    match_idx_reg <= idx_reg;
                end
                if (!cur_valid && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
            end else begin
                if (cur_valid && (!min_reg || cur_key < min_key_reg)) begin
                    min_reg     <= 1'b1;
                    min_idx_reg <= idx_reg;
                    min_key_reg <= cur_key;
                end
            end
        end
        if (cmd.do_register) begin
            new_id_reg <= key_reg;
        end
        if (cmd.do_fire) begin
            fired_reg <= 1'b1;
            fkey_reg  <= min_key_reg;
            ftag_reg  <= tag_mem[min_idx_reg];
            key_reg   <= now_reg + period_mem[min_idx_reg];
        end
        if (cmd.set_dup) begin
            status_reg <= ST_DUP_KEY;
        end
        if (cmd.set_notfound) begin
            status_reg <= (req_reg == REQ_UNREGISTER) ? ST_NOT_FOUND : ST_FULL;
        end
        if (cmd.set_sleep) begin
            if (min_reg) begin
                sleep_reg <= min_key_reg - now_reg;
                empty_reg <= 1'b0;
            end else begin
                sleep_reg <= '1;
                empty_reg <= 1'b1;
            end
        end
    end

    assign r_status      = status_reg;
    assign r_new_id      = new_id_reg;
    assign r_fired       = fired_reg;
    assign r_fired_key   = fkey_reg;
    assign r_fired_tag   = ftag_reg;
    assign r_sleep_ms    = sleep_reg;
    assign r_table_empty = empty_reg;

endmodule

[rtl/core/tts_ctrl.sv]
// controller state machine for the timer table scheduler
// depends on tts_pkg; drives tts_datapath through dp_cmd_t
module tts_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    output logic              m_valid,
    input  logic              m_ready,
    output tts_pkg::dp_cmd_t  cmd,
    input  tts_pkg::dp_stat_t stat
);
    import tts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_REG_SCAN, S_REG_DO, S_UNREG_SCAN, S_UNREG_DO,
        S_MIN1, S_FIRE, S_DUP_SCAN, S_REARM, S_MIN2, S_SLEEP, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    unique case (req_t'(s_req_type))
                        REQ_REG_ONESHOT, REQ_REG_PERIODIC: state_next = S_REG_SCAN;
                        REQ_UNREGISTER:                    state_next = S_UNREG_SCAN;
                        REQ_PROCESS:                       state_next = S_MIN1;
                        default:                           state_next = S_IDLE;
                    endcase
                end
            end
            S_REG_SCAN: begin
                cmd.scan_step = 1'b1;
                cmd.scan_mode = SCAN_MATCH;
                if (stat.scan_last) state_next = S_REG_DO;
            end
            S_REG_DO: begin
                if (stat.match_found) cmd.set_dup = 1'b1;
                else if (!stat.free_found) cmd.set_notfound = 1'b1;
                else cmd.do_register = 1'b1;
                state_next = S_OUT;
            end
            S_UNREG_SCAN: begin
                cmd.scan_step = 1'b1;
                cmd.scan_mode = SCAN_MATCH;
                if (stat.scan_last) state_next = S_UNREG_DO;
            end
            S_UNREG_DO: begin
                if (stat.match_found) cmd.do_free_match = 1'b1;
                else cmd.set_notfound = 1'b1;
                state_next = S_OUT;
            end
            S_MIN1: begin
                cmd.scan_step = 1'b1;
                cmd.scan_mode = SCAN_MIN;
                if (stat.scan_last) state_next = S_FIRE;
            end
            S_FIRE: begin
                if (stat.min_found && stat.min_due) begin
                    cmd.scan_start = 1'b1;
                    cmd.do_fire    = 1'b1;
                    state_next     = stat.min_periodic ? S_DUP_SCAN : S_MIN2;
                end else begin
                    state_next = S_SLEEP;
                end
            end
            S_DUP_SCAN: begin
                cmd.scan_step = 1'b1;
                cmd.scan_mode = SCAN_MATCH;
                if (stat.scan_last) state_next = S_REARM;
            end
            S_REARM: begin
                cmd.do_fire    = 1'b0;
                cmd.scan_start = 1'b1;
                if (stat.match_found) cmd.set_dup = 1'b1;
                else cmd.do_rearm = 1'b1;
                state_next = S_MIN2;
            end
            S_MIN2: begin
                cmd.scan_step = 1'b1;
                cmd.scan_mode = SCAN_MIN;
                if (stat.scan_last) state_next = S_SLEEP;
            end
            S_SLEEP: begin
                cmd.set_sleep = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= (state_next == S_OUT);
        end
    end

endmodule
